// ----- src/tps4_pkg.sv -----
// ----------------------------------------------------------------------------
// tps4_pkg
// Shared types, constants and helper functions for the four-track priority
// sorter.
// ----------------------------------------------------------------------------
package tps4_pkg;

   // Field widths of one track.
   localparam int RATE_W = 24;
   localparam int DIST_W = 24;
   localparam int TAG_W  = 16;
   localparam int SLOT_W = 2;
   localparam int TRACKS = 4;

   // Packed stream widths: 66 payload bits padded up to whole bytes.
   localparam int TRACK_BITS = RATE_W + DIST_W + 2 + TAG_W;
   localparam int TDATA_W    = ((TRACK_BITS + 7) / 8) * 8;
   localparam int PAD_W      = TDATA_W - TRACK_BITS;

   // A distance at or below 0.1 (Q16.8 raw 25) gives a zero ratio.
   localparam logic [DIST_W-1:0] ZERO_DIST_MAX = 24'd25;
   // Near-zero test: |rate| * 10000 < distance.
   localparam int NEAR_SCALE = 10000;
   localparam int NEAR_W     = RATE_W + 16;

   // Product width of a signed rate by a positive distance.
   localparam int PROD_W = 2 * (RATE_W + 1);

   // Compare-swap sequencing.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;
   localparam logic [SLOT_W-1:0] RANK_LAST = 2'd3;

   // Batch queue between the load side and the sort side. Depth is a power
   // of two so that the pointers wrap on their own.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [TAG_W-1:0]  track_tag;
      logic              radar_detected;
      logic              is_friend;
      logic [DIST_W-1:0] distance;
      logic [RATE_W-1:0] closing_rate;
   } track_type;

   typedef track_type [TRACKS-1:0] batch_type;

   typedef struct packed {
      logic      valid;
      batch_type batch;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Slot pairs worked on by the network steps.
   typedef enum logic [1:0] {
      PAIR_01,
      PAIR_12,
      PAIR_23
   } pair_type;

   // Fixed six-step network: (0,1) (2,3) (1,2) (0,1) (2,3) (1,2).
   function automatic pair_type pair_of_step(input logic [STEP_W-1:0] step);
      pair_type p;
      case (step) inside
         3'd0, 3'd3: p = PAIR_01;
         3'd1, 3'd4: p = PAIR_23;
         default:    p = PAIR_12;
      endcase
      return p;
   endfunction

   // Numerator of the ratio: zero for a track that is too close.
   function automatic logic [RATE_W-1:0] track_num(input track_type t);
      return (t.distance > ZERO_DIST_MAX) ? t.closing_rate : '0;
   endfunction

   // Denominator of the ratio: one for a track that is too close.
   function automatic logic [DIST_W-1:0] track_den(input track_type t);
      return (t.distance > ZERO_DIST_MAX) ? t.distance : DIST_W'(1);
   endfunction

endpackage

// ----- src/tps4_front.sv -----
// ----------------------------------------------------------------------------
// tps4_front
// Load side: writes each accepted track into its slot and, on a go item,
// hands a snapshot of all four slots to the batch queue.
// ----------------------------------------------------------------------------
module tps4_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [tps4_pkg::SLOT_W-1:0] in_slot,
   input  tps4_pkg::track_type      in_track,
   input  logic                     in_go,
   input  tps4_pkg::q_status_type   q_status,
   output tps4_pkg::push_type       push
);
   import tps4_pkg::*;

   batch_type slot_ff;
   batch_type slot_in;
   logic      accept;

   // Tracks are taken whenever the queue can hold another batch.
   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   // The new track overwrites its slot; a go snapshot includes it.
   always_comb begin
      slot_in = slot_ff;
      if (accept) begin
         slot_in[in_slot] = in_track;
      end
   end

   assign push.valid = accept && in_go;
   assign push.batch = slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

// ----- src/tps4_queue.sv -----
// ----------------------------------------------------------------------------
// tps4_queue
// Short queue of four-track batches between the load side and the sort side.
// ----------------------------------------------------------------------------
module tps4_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tps4_pkg::push_type     push,
   input  logic                   pop,
   output tps4_pkg::batch_type    head,
   output tps4_pkg::q_status_type status
);
   import tps4_pkg::*;

   batch_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff;
   logic [QPTR_W-1:0] wr_in;
   logic [QPTR_W-1:0] rd_ff;
   logic [QPTR_W-1:0] rd_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign head         = mem_ff[rd_ff];
   assign status.full  = (count_ff == QCNT_W'(QDEPTH));
   assign status.empty = (count_ff == '0);

   // Pointer and fill-count update.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push.valid) begin
         wr_in = wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = rd_ff + QPTR_W'(1);
      end
      if (push.valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Batch storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.batch;
      end
   end

   // The load side must never push into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !status.full)
      else $error("batch pushed into a full queue");

   // The fill count never passes the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue fill count out of range");

endmodule

// ----- src/tps4_back.sv -----
// ----------------------------------------------------------------------------
// tps4_back
// Sort side: takes a batch from the queue, runs the six compare-swap steps
// on one shared multiplier and emits the four tracks in ranked order.
// ----------------------------------------------------------------------------
module tps4_back (
   input  logic                        clock,
   input  logic                        reset,
   input  tps4_pkg::batch_type         head,
   input  tps4_pkg::q_status_type      q_status,
   output logic                        pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output tps4_pkg::track_type         out_track,
   output logic [tps4_pkg::SLOT_W-1:0] out_rank,
   output logic                        out_last
);
   import tps4_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_SWAP_EMIT
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic                 sorted_ff;
   logic                 sorted_in;
   logic [STEP_W-1:0]    step_ff;
   logic [STEP_W-1:0]    step_in;
   logic [SLOT_W-1:0]    emit_ff;
   logic [SLOT_W-1:0]    emit_in;
   batch_type            w_ff;
   batch_type            w_in;
   logic signed [PROD_W-1:0] pa_ff;
   logic signed [PROD_W-1:0] pa_in;
   logic signed [PROD_W-1:0] pb_ff;
   logic signed [PROD_W-1:0] pb_in;
   logic                 near_a_ff;
   logic                 near_a_in;
   logic                 near_b_ff;
   logic                 near_b_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   track_type            out_track_ff;
   track_type            out_track_in;
   logic [SLOT_W-1:0]    out_rank_ff;
   logic [SLOT_W-1:0]    out_rank_in;
   logic                 out_last_ff;
   logic                 out_last_in;

   pair_type             pair;
   track_type            trk_a;
   track_type            trk_b;
   track_type            trk_x;
   track_type            trk_y;
   logic [RATE_W-1:0]    num_x;
   logic [RATE_W-1:0]    mag_x;
   logic signed [PROD_W-1:0] prod;
   logic                 near_x;
   logic                 do_swap;

   // Operand pair of the current step.
   assign pair = pair_of_step(step_ff);

   always_comb begin
      unique case (pair)
         PAIR_01: begin
            trk_a = w_ff[0];
            trk_b = w_ff[1];
         end
         PAIR_12: begin
            trk_a = w_ff[1];
            trk_b = w_ff[2];
         end
         PAIR_23: begin
            trk_a = w_ff[2];
            trk_b = w_ff[3];
         end
         default: begin
            trk_a = w_ff[0];
            trk_b = w_ff[1];
         end
      endcase
   end

   // First pass forms num(A)*den(B), second pass num(B)*den(A).
   assign trk_x = (state_ff == ST_MUL_A) ? trk_a : trk_b;
   assign trk_y = (state_ff == ST_MUL_A) ? trk_b : trk_a;
   assign num_x = track_num(trk_x);
   assign mag_x = num_x[RATE_W-1] ? (~num_x + RATE_W'(1)) : num_x;
   assign prod  = PROD_W'($signed(num_x)) * PROD_W'($signed({1'b0, track_den(trk_y)}));
   assign near_x = (NEAR_W'(mag_x) * NEAR_W'(NEAR_SCALE)) < NEAR_W'(track_den(trk_x));

   // Swap rule for the pair, from the registered products.
   always_comb begin
      do_swap = trk_a.is_friend || !trk_a.radar_detected;
      if (trk_a.radar_detected && trk_b.radar_detected) begin
         if (near_a_ff && near_b_ff) begin
            do_swap = do_swap || (trk_a.distance > trk_b.distance);
         end else begin
            do_swap = do_swap || (pa_ff < pb_ff);
         end
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      sorted_in    = sorted_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      w_in         = w_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      near_a_in    = near_a_ff;
      near_b_in    = near_b_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_track_in = out_track_ff;
      out_rank_in  = out_rank_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               w_in     = head;
               step_in  = '0;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            pa_in     = prod;
            near_a_in = near_x;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            pb_in     = prod;
            near_b_in = near_x;
            sorted_in = 1'b0;
            state_in  = ST_SWAP_EMIT;
         end
         ST_SWAP_EMIT: begin
            if (!sorted_ff) begin
               // Compare-swap step.
               if (do_swap) begin
                  unique case (pair)
                     PAIR_01: begin
                        w_in[0] = w_ff[1];
                        w_in[1] = w_ff[0];
                     end
                     PAIR_12: begin
                        w_in[1] = w_ff[2];
                        w_in[2] = w_ff[1];
                     end
                     PAIR_23: begin
                        w_in[2] = w_ff[3];
                        w_in[3] = w_ff[2];
                     end
                     default: begin
                        w_in = w_ff;
                     end
                  endcase
               end
               if (step_ff == LAST_STEP) begin
                  sorted_in = 1'b1;
                  emit_in   = '0;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = ST_MUL_A;
               end
            end else if (!out_valid_ff || out_ready) begin
               // Ranked output: shift the sorted tracks out from slot 0.
               out_valid_in = 1'b1;
               out_track_in = w_ff[0];
               out_rank_in  = emit_ff;
               out_last_in  = (emit_ff == RANK_LAST);
               for (int i = 0; i < TRACKS - 1; i++) begin
                  w_in[i] = w_ff[i+1];
               end
               emit_in = emit_ff + SLOT_W'(1);
               if (emit_ff == RANK_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sorted_ff    <= 1'b0;
         step_ff      <= '0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sorted_ff    <= sorted_in;
         step_ff      <= step_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
      end
      w_ff         <= w_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      near_a_ff    <= near_a_in;
      near_b_ff    <= near_b_in;
      out_track_ff <= out_track_in;
      out_rank_ff  <= out_rank_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_track = out_track_ff;
   assign out_rank  = out_rank_ff;
   assign out_last  = out_last_ff;

   // The step counter stays within the six network steps.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= LAST_STEP)
      else $error("compare-swap step out of range");

   // Only the fourth ranked track closes a run.
   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_rank_ff == RANK_LAST))
      else $error("run closed on a rank other than the last");

   // A waiting batch is taken at once and starts the first multiply.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !q_status.empty) |=> (state_ff == ST_MUL_A))
      else $error("queued batch not started");

   // The queue is popped only when it holds a batch.
   a_pop_safe: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from an empty queue");

endmodule

// ----- src/track_priority_sort4.sv -----
// ----------------------------------------------------------------------------
// track_priority_sort4
// Ranks four radar tracks by threat priority with a six-step compare-swap
// network and streams them out highest priority first.
// ----------------------------------------------------------------------------
// Tracks load one per cycle into four slots while the two-batch queue has
// room. A transaction with tlast set loads its slot and queues a snapshot of
// all four slots; the sorter then takes the batch, runs each of the six
// compare-swap steps as ST_MUL_A, ST_MUL_B and ST_SWAP_EMIT (two passes
// through the one shared rate-by-distance multiplier, then the compare and
// swap) and emits the ranked results, holding each while the output side
// stalls. Loading of the next batch overlaps with sorting.
// Slots that were never loaded sort with all-zero contents.
module track_priority_sort4 (
   input  logic                         clock,
   input  logic                         reset,
   // Input channel.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // tdata: closing_rate[23:0], distance[47:24], is_friend[48],
   // radar_detected[49], track_tag[65:50], zero padding[71:66].
   input  logic [tps4_pkg::TDATA_W-1:0] req_tdata,
   // tuser: track_slot[1:0].
   input  logic [tps4_pkg::SLOT_W-1:0]  req_tuser,
   input  logic                         req_tlast,
   // Result channel.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // tdata: out_closing_rate[23:0], out_distance[47:24], out_is_friend[48],
   // out_radar_detected[49], out_track_tag[65:50], zero padding[71:66].
   output logic [tps4_pkg::TDATA_W-1:0] rsp_tdata,
   // tuser: rank[1:0].
   output logic [tps4_pkg::SLOT_W-1:0]  rsp_tuser,
   output logic                         rsp_tlast
);
   import tps4_pkg::*;

   track_type    in_track;
   track_type    out_track;
   push_type     push;
   q_status_type q_status;
   batch_type    head;
   logic         pop;

   assign in_track  = track_type'(req_tdata[TRACK_BITS-1:0]);
   assign rsp_tdata = {PAD_W'(0), out_track};

   tps4_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_slot  (req_tuser),
      .in_track (in_track),
      .in_go    (req_tlast),
      .q_status (q_status),
      .push     (push)
   );

   tps4_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   tps4_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_track (out_track),
      .out_rank  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule
